// ===== rtl/wide_segment_quad_expander_core_defines.svh =====
// assertion macros shared by the quad expander rtl
`ifndef WIDE_SEGMENT_QUAD_EXPANDER_CORE_DEFINES_SVH
`define WIDE_SEGMENT_QUAD_EXPANDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define WSQE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("quad expander check failed");

// next-cycle implication check
`define WSQE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quad expander check failed");

`else

`define WSQE_ASSERT_IMP(name, clk, rst, ante, cons)
`define WSQE_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/wsqe_pkg.sv =====
// shared constants and types of the quad expander
package wsqe_pkg;

   // width of a csr word and of the csr index
   localparam int REG_BITS   = 12;
   localparam int CSR_IDX_W  = 2;

   // guard fraction bits of the offsets
   localparam int GUARD_BITS = 16;

   // the larger normalized magnitude lies in [2^30, 2^31)
   localparam int NORM_BITS  = 31;

   // reset geometry in whole units
   localparam int WALL_THICK  = 10;
   localparam int THICK_DIV   = 2;
   localparam int EXT_UNITS   = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH    = 2'd0,
      CSR_END_EXTENSION = 2'd1
   } csr_index_type;

endpackage

// ===== rtl/wide_segment_quad_expander_core.sv =====
// top level of the thick line to quad expander
//
// Turns each segment (begin and end point, signed fixed point) into the four
// corners of a rectangle lengthened by end_extension at both ends and widened
// by half_width on both sides. A segment is taken in every cycle that start
// is high (busy stays low), and its word appears on the rsp_ ports with
// rsp_valid high for one cycle, after stages 1 to 4, the 32-stage square
// root, the multiply register, the quotient-bit-per-stage dividers and
// final stages 1 and 2. The receiver cannot stall, so results must be taken
// as they come. A zero-length segment sets rsp_degenerate and returns the
// begin point as every corner. csr writes are meant for times when no
// segment is in flight.
`include "wide_segment_quad_expander_core_defines.svh"

module wide_segment_quad_expander_core #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_BITS-1:0]        req_begin_x,
   input  logic signed [COORD_BITS-1:0]        req_begin_y,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   output logic                                rsp_valid,
   output logic signed [COORD_BITS-1:0]        rsp_corner0_x,
   output logic signed [COORD_BITS-1:0]        rsp_corner0_y,
   output logic signed [COORD_BITS-1:0]        rsp_corner1_x,
   output logic signed [COORD_BITS-1:0]        rsp_corner1_y,
   output logic signed [COORD_BITS-1:0]        rsp_corner2_x,
   output logic signed [COORD_BITS-1:0]        rsp_corner2_y,
   output logic signed [COORD_BITS-1:0]        rsp_corner3_x,
   output logic signed [COORD_BITS-1:0]        rsp_corner3_y,
   output logic                                rsp_degenerate,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  logic [wsqe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wsqe_pkg::REG_BITS-1:0]       csr_wdata
);
   import wsqe_pkg::*;

   localparam int CW      = COORD_BITS;
   localparam int DW_D    = CW + 1;
   localparam int PW      = $clog2(DW_D);
   localparam int EW      = DW_D + NORM_BITS - 1;
   localparam int GB      = GUARD_BITS;
   localparam int NB      = NORM_BITS;
   localparam int SQ_W    = 2 * NB;
   localparam int SQS     = NB + 1;
   localparam int RAD_W   = 2 * SQS;
   localparam int REG_W   = (FRAC_BITS + 3 > REG_BITS) ? FRAC_BITS + 3 : REG_BITS;
   localparam int PROD_W  = REG_W + NB;
   localparam int QW      = REG_W + GB;
   localparam int OW      = QW + 1;
   localparam int SW      = ((CW + GB > QW + 1) ? CW + GB : QW + 1) + 2;
   localparam int RW      = SW - GB;
   localparam int SIDE_LAT = SQS + 1 + QW;
   localparam int LATENCY  = 4 + SIDE_LAT + 2;
   localparam logic [REG_W-1:0] HW_RESET  = REG_W'((WALL_THICK / THICK_DIV) << FRAC_BITS);
   localparam logic [REG_W-1:0] EXT_RESET = REG_W'(EXT_UNITS << FRAC_BITS);
   localparam logic signed [RW-1:0] C_MAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [RW-1:0] C_MIN = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic                 sx;
      logic                 sy;
      logic                 degen;
      logic [NB-1:0]        an;
      logic [NB-1:0]        bn;
   } side_type;

   // csr registers
   logic [REG_W-1:0] hw_ff, hw_in, ext_ff, ext_in;

   always_comb begin
      hw_in  = hw_ff;
      ext_in = ext_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HALF_WIDTH:    hw_in  = REG_W'(csr_wdata);
            CSR_END_EXTENSION: ext_in = REG_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff  <= HW_RESET;
         ext_ff <= EXT_RESET;
      end else begin
         hw_ff  <= hw_in;
         ext_ff <= ext_in;
      end
   end

   assign busy = 1'b0;

   // stage 1: capture points and form the difference vector
   logic                   s1_vld_ff;
   logic signed [CW-1:0]   s1_bx_ff, s1_by_ff, s1_ex_ff, s1_ey_ff;
   logic signed [DW_D-1:0] s1_dx_ff, s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= start && !busy;
      s1_bx_ff <= req_begin_x;
      s1_by_ff <= req_begin_y;
      s1_ex_ff <= req_end_x;
      s1_ey_ff <= req_end_y;
      s1_dx_ff <= DW_D'(req_end_x) - DW_D'(req_begin_x);
      s1_dy_ff <= DW_D'(req_end_y) - DW_D'(req_begin_y);
   end

   // stage 2: magnitudes, shared normalizing shift
   logic [DW_D-1:0] s2_a, s2_b, s2_or;
   logic [PW-1:0]   s2_msb;
   logic [EW-1:0]   s2_aw, s2_bw;
   side_type        s2_side_in, s2_side_ff;
   logic            s2_vld_ff;

   always_comb begin
      s2_a   = s1_dx_ff[DW_D-1] ? (~s1_dx_ff + 1'b1) : s1_dx_ff;
      s2_b   = s1_dy_ff[DW_D-1] ? (~s1_dy_ff + 1'b1) : s1_dy_ff;
      s2_or  = s2_a | s2_b;
      s2_msb = '0;
      for (int i = 0; i < DW_D; i++) begin
         if (s2_or[i]) s2_msb = PW'(i);
      end
      s2_aw = (EW'(s2_a) << (NB - 1)) >> s2_msb;
      s2_bw = (EW'(s2_b) << (NB - 1)) >> s2_msb;
      s2_side_in.bx    = s1_bx_ff;
      s2_side_in.by    = s1_by_ff;
      s2_side_in.ex    = s1_ex_ff;
      s2_side_in.ey    = s1_ey_ff;
      s2_side_in.sx    = s1_dx_ff[DW_D-1];
      s2_side_in.sy    = s1_dy_ff[DW_D-1];
      s2_side_in.degen = (s2_or == '0);
      s2_side_in.an    = s2_aw[NB-1:0];
      s2_side_in.bn    = s2_bw[NB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_side_ff <= s2_side_in;
   end

   // stage 3: squares
   logic [SQ_W-1:0] s3_aa_ff, s3_bb_ff;
   side_type        s3_side_ff;
   logic            s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
      s3_side_ff <= s2_side_ff;
      s3_aa_ff   <= SQ_W'(s2_side_ff.an) * SQ_W'(s2_side_ff.an);
      s3_bb_ff   <= SQ_W'(s2_side_ff.bn) * SQ_W'(s2_side_ff.bn);
   end

   // stage 4: squared length
   logic [RAD_W-1:0] s4_rad_ff;
   side_type         s4_side_ff;
   logic             s4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= s3_vld_ff;
      s4_side_ff <= s3_side_ff;
      s4_rad_ff  <= RAD_W'(s3_aa_ff) + RAD_W'(s3_bb_ff);
   end

   // length through the square root pipe
   logic [SQS-1:0] len;

   wsqe_isqrt #(.STEPS(SQS)) u_isqrt (
      .clock    (clock),
      .radicand (s4_rad_ff),
      .root     (len)
   );

   // side words travel alongside the root and divider pipes
   side_type side_ff [SIDE_LAT];
   logic     vld_ff  [SIDE_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= s4_side_ff;
      for (int k = 1; k < SIDE_LAT; k++) side_ff[k] <= side_ff[k-1];
      if (reset) begin
         for (int k = 0; k < SIDE_LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= s4_vld_ff;
         for (int k = 1; k < SIDE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // offset numerators: ext*a, ext*b, hw*a, hw*b
   side_type          mul_side;
   logic [SQS-1:0]    mul_len_ff;
   logic [PROD_W-1:0] mul_prod_ff [4];

   assign mul_side = side_ff[SQS-1];

   always_ff @(posedge clock) begin
      mul_len_ff     <= len;
      mul_prod_ff[0] <= PROD_W'(ext_ff) * PROD_W'(mul_side.an);
      mul_prod_ff[1] <= PROD_W'(ext_ff) * PROD_W'(mul_side.bn);
      mul_prod_ff[2] <= PROD_W'(hw_ff) * PROD_W'(mul_side.an);
      mul_prod_ff[3] <= PROD_W'(hw_ff) * PROD_W'(mul_side.bn);
   end

   // four dividers by the length
   logic [QW-1:0] quo [4];

   for (genvar i = 0; i < 4; i++) begin : g_div
      wsqe_div #(.DW(SQS), .QW(QW)) u_div (
         .clock (clock),
         .num   ({{(SQS-NB){1'b0}}, mul_prod_ff[i], {GB{1'b0}}}),
         .den   (mul_len_ff),
         .quo   (quo[i])
      );
   end

   // final stage 1: signed offsets, corner sums, rounding
   side_type             fsd;
   logic signed [OW-1:0] ext_x, ext_y, nrm_x, nrm_y;
   logic signed [SW-1:0] pbx, pby, pex, pey, half;
   logic signed [SW-1:0] sum [8];
   logic signed [RW-1:0] f1_rnd_in [8];
   logic signed [RW-1:0] f1_rnd_ff [8];
   logic signed [CW-1:0] f1_bx_ff, f1_by_ff;
   logic                 f1_vld_ff, f1_degen_ff;

   assign fsd = side_ff[SIDE_LAT-1];

   always_comb begin
      ext_x = $signed({1'b0, quo[0]});
      ext_y = $signed({1'b0, quo[1]});
      nrm_y = $signed({1'b0, quo[2]});
      nrm_x = $signed({1'b0, quo[3]});
      if (fsd.sx) begin
         ext_x = -ext_x;
         nrm_y = -nrm_y;
      end
      if (fsd.sy) ext_y = -ext_y;
      else        nrm_x = -nrm_x;
      pbx  = (SW'($signed(fsd.bx)) <<< GB) - SW'(ext_x);
      pby  = (SW'($signed(fsd.by)) <<< GB) - SW'(ext_y);
      pex  = (SW'($signed(fsd.ex)) <<< GB) + SW'(ext_x);
      pey  = (SW'($signed(fsd.ey)) <<< GB) + SW'(ext_y);
      half = SW'(1) <<< (GB - 1);
      sum[0] = pbx + SW'(nrm_x);
      sum[1] = pby + SW'(nrm_y);
      sum[2] = pbx - SW'(nrm_x);
      sum[3] = pby - SW'(nrm_y);
      sum[4] = pex - SW'(nrm_x);
      sum[5] = pey - SW'(nrm_y);
      sum[6] = pex + SW'(nrm_x);
      sum[7] = pey + SW'(nrm_y);
      // floor of the shifted value rounds halves upward
      for (int i = 0; i < 8; i++) begin
         f1_rnd_in[i] = RW'((sum[i] + half) >>> GB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f1_vld_ff <= 1'b0;
      else       f1_vld_ff <= vld_ff[SIDE_LAT-1];
      f1_degen_ff <= fsd.degen;
      f1_bx_ff    <= fsd.bx;
      f1_by_ff    <= fsd.by;
      for (int i = 0; i < 8; i++) f1_rnd_ff[i] <= f1_rnd_in[i];
   end

   // final stage 2: clamp to the coordinate range, output word
   logic [CW-1:0] out_in [8];
   logic [CW-1:0] out_ff [8];
   logic          sat_in, sat_ff, degen_ff, valid_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (f1_rnd_ff[i] > C_MAX) begin
            out_in[i] = C_MAX[CW-1:0];
            sat_in    = 1'b1;
         end else if (f1_rnd_ff[i] < C_MIN) begin
            out_in[i] = C_MIN[CW-1:0];
            sat_in    = 1'b1;
         end else begin
            out_in[i] = f1_rnd_ff[i][CW-1:0];
         end
      end
      // zero-length segment: begin point everywhere
      if (f1_degen_ff) begin
         sat_in = 1'b0;
         for (int i = 0; i < 4; i++) begin
            out_in[2*i]   = f1_bx_ff;
            out_in[2*i+1] = f1_by_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= f1_vld_ff;
      sat_ff   <= sat_in;
      degen_ff <= f1_degen_ff;
      for (int i = 0; i < 8; i++) out_ff[i] <= out_in[i];
   end

   assign rsp_valid      = valid_ff;
   assign rsp_corner0_x  = out_ff[0];
   assign rsp_corner0_y  = out_ff[1];
   assign rsp_corner1_x  = out_ff[2];
   assign rsp_corner1_y  = out_ff[3];
   assign rsp_corner2_x  = out_ff[4];
   assign rsp_corner2_y  = out_ff[5];
   assign rsp_corner3_x  = out_ff[6];
   assign rsp_corner3_y  = out_ff[7];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

   // checks
   `WSQE_ASSERT_IMP(a_fixed_latency, clock, reset, start && !busy, ##LATENCY rsp_valid)
   `WSQE_ASSERT_IMP(a_degen_no_sat, clock, reset, rsp_valid && rsp_degenerate, !rsp_saturated)
   `WSQE_ASSERT_IMP(a_degen_corners, clock, reset, rsp_valid && rsp_degenerate, (rsp_corner0_x == rsp_corner2_x && rsp_corner1_y == rsp_corner3_y))
   `WSQE_ASSERT_NXT(a_degen_flag, clock, reset, f1_vld_ff && f1_degen_ff, rsp_valid && rsp_degenerate)

endmodule

// ===== rtl/wsqe_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module wsqe_isqrt #(
   parameter int STEPS = 32
) (
   input  logic                 clock,
   input  logic [2*STEPS-1:0]   radicand,
   output logic [STEPS-1:0]     root
);
   logic [STEPS+1:0]   rem_ff  [STEPS];
   logic [STEPS-1:0]   root_ff [STEPS];
   logic [2*STEPS-1:0] rad_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [STEPS-1:0]   rem_prev;
      logic [STEPS-1:0]   root_prev;
      logic [2*STEPS-1:0] rad_prev;
      logic [STEPS+1:0]   rem_sh;
      logic [STEPS+1:0]   trial;
      logic [STEPS+1:0]   rem_in;
      logic [STEPS-1:0]   root_in;
      logic [2*STEPS-1:0] rad_in;
      logic               ge;

      // previous stage, or the radicand at the head
      if (k == 0) begin : g_head
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_body
         assign rem_prev  = rem_ff[k-1][STEPS-1:0];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // bring down two bits and try the next root bit
      always_comb begin
         rem_sh  = {rem_prev, rad_prev[2*STEPS-1 -: 2]};
         trial   = {root_prev, 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[STEPS-2:0], ge};
         rad_in  = rad_prev << 2;
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
      end
   end

   assign root = root_ff[STEPS-1];
endmodule

// ===== rtl/wsqe_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module wsqe_div #(
   parameter int DW = 32,
   parameter int QW = 28
) (
   input  logic              clock,
   input  logic [DW+QW-1:0]  num,
   input  logic [DW-1:0]     den,
   output logic [QW-1:0]     quo
);
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [DW:0]   sh;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] low_in;
      logic [QW-1:0] quo_in;
      logic          ge;

      // high part of the numerator starts as partial remainder
      if (k == 0) begin : g_head
         assign rem_prev = num[DW+QW-1:QW];
         assign low_prev = num[QW-1:0];
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_body
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // shift in one numerator bit, subtract when it fits
      always_comb begin
         sh     = {rem_prev, low_prev[QW-1]};
         diff   = sh - {1'b0, den_prev};
         ge     = (sh >= {1'b0, den_prev});
         rem_in = ge ? diff[DW-1:0] : sh[DW-1:0];
         low_in = low_prev << 1;
         quo_in = {quo_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         low_ff[k] <= low_in;
         den_ff[k] <= den_prev;
         quo_ff[k] <= quo_in;
      end
   end

   assign quo = quo_ff[QW-1];
endmodule

// ===== verif/quad_corner_checker.sv =====
// checker for the quad expander: predicts each corner word and compares it
`timescale 1ns / 1ps

module quad_corner_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [15:0]            req_begin_x,
   input  logic signed [15:0]            req_begin_y,
   input  logic signed [15:0]            req_end_x,
   input  logic signed [15:0]            req_end_y,
   input  logic                          rsp_valid,
   input  logic signed [15:0]            rsp_corner0_x,
   input  logic signed [15:0]            rsp_corner0_y,
   input  logic signed [15:0]            rsp_corner1_x,
   input  logic signed [15:0]            rsp_corner1_y,
   input  logic signed [15:0]            rsp_corner2_x,
   input  logic signed [15:0]            rsp_corner2_y,
   input  logic signed [15:0]            rsp_corner3_x,
   input  logic signed [15:0]            rsp_corner3_y,
   input  logic                          rsp_degenerate,
   input  logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic [wsqe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsqe_pkg::REG_BITS-1:0]  csr_wdata,
   output int                            fail_count,
   output int                            words_pending
);
   import wsqe_pkg::*;

   typedef struct {
      logic signed [15:0] cx [4];
      logic signed [15:0] cy [4];
      logic               degenerate;
      logic               saturated;
   } quad_word_type;

   quad_word_type quad_queue [$];
   logic [REG_BITS-1:0] half_width_q;
   logic [REG_BITS-1:0] end_ext_q;

   assign words_pending = quad_queue.size();

   // integer square root, floor
   function automatic longint unsigned root_floor(longint unsigned q);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > q) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (q >= res + bitv) begin
            q = q - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // drop guard bits rounding half up, then clamp to 16 bits
   function automatic logic signed [15:0] round_clamp(longint v, inout logic sat);
      longint r;
      r = (v + 64'sd32768) >>> GUARD_BITS;
      if (r > 32767) begin
         r = 32767;
         sat = 1'b1;
      end
      if (r < -32768) begin
         r = -32768;
         sat = 1'b1;
      end
      return r[15:0];
   endfunction

   function automatic quad_word_type expand_segment(longint bx, longint by, longint ex,
                                                    longint ey, longint unsigned hw,
                                                    longint unsigned ext);
      quad_word_type w;
      longint dx, dy, ext_x, ext_y, nrm_x, nrm_y, pbx, pby, pex, pey;
      longint unsigned a, b, len;
      logic sat;
      dx = ex - bx;
      dy = ey - by;
      sat = 1'b0;
      if (dx == 0 && dy == 0) begin
         for (int i = 0; i < 4; i++) begin
            w.cx[i] = bx[15:0];
            w.cy[i] = by[15:0];
         end
         w.degenerate = 1'b1;
         w.saturated = 1'b0;
         return w;
      end
      a = (dx < 0) ? -dx : dx;
      b = (dy < 0) ? -dy : dy;
      // normalize larger magnitude into [2^30, 2^31)
      while (((a > b) ? a : b) >= (64'd1 << NORM_BITS)) begin
         a = a >> 1;
         b = b >> 1;
      end
      while (((a > b) ? a : b) < (64'd1 << (NORM_BITS - 1))) begin
         a = a << 1;
         b = b << 1;
      end
      len = root_floor(a * a + b * b);
      ext_x = ((ext * a) << GUARD_BITS) / len;
      ext_y = ((ext * b) << GUARD_BITS) / len;
      nrm_y = ((hw * a) << GUARD_BITS) / len;
      nrm_x = ((hw * b) << GUARD_BITS) / len;
      if (dx < 0) begin
         ext_x = -ext_x;
         nrm_y = -nrm_y;
      end
      if (dy >= 0) nrm_x = -nrm_x;
      if (dy < 0) ext_y = -ext_y;
      pbx = (bx <<< GUARD_BITS) - ext_x;
      pby = (by <<< GUARD_BITS) - ext_y;
      pex = (ex <<< GUARD_BITS) + ext_x;
      pey = (ey <<< GUARD_BITS) + ext_y;
      w.cx[0] = round_clamp(pbx + nrm_x, sat);
      w.cy[0] = round_clamp(pby + nrm_y, sat);
      w.cx[1] = round_clamp(pbx - nrm_x, sat);
      w.cy[1] = round_clamp(pby - nrm_y, sat);
      w.cx[2] = round_clamp(pex - nrm_x, sat);
      w.cy[2] = round_clamp(pey - nrm_y, sat);
      w.cx[3] = round_clamp(pex + nrm_x, sat);
      w.cy[3] = round_clamp(pey + nrm_y, sat);
      w.degenerate = 1'b0;
      w.saturated = sat;
      return w;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // register shadow, predict on accept, compare on result strobe
   always @(posedge clock) begin
      quad_word_type w;
      if (reset) begin
         half_width_q <= REG_BITS'((WALL_THICK / THICK_DIV) << 4);
         end_ext_q <= REG_BITS'(EXT_UNITS << 4);
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HALF_WIDTH) half_width_q <= csr_wdata;
            else if (csr_index == CSR_END_EXTENSION) end_ext_q <= csr_wdata;
         end
         if (start && !busy)
            quad_queue.push_back(expand_segment(req_begin_x, req_begin_y, req_end_x,
                                                req_end_y, half_width_q, end_ext_q));
         if (rsp_valid) begin
            if (quad_queue.size() == 0) begin
               $error("result word with no segment outstanding");
               fail_count++;
            end else begin
               w = quad_queue.pop_front();
               check_field("corner0_x", w.cx[0], rsp_corner0_x);
               check_field("corner0_y", w.cy[0], rsp_corner0_y);
               check_field("corner1_x", w.cx[1], rsp_corner1_x);
               check_field("corner1_y", w.cy[1], rsp_corner1_y);
               check_field("corner2_x", w.cx[2], rsp_corner2_x);
               check_field("corner2_y", w.cy[2], rsp_corner2_y);
               check_field("corner3_x", w.cx[3], rsp_corner3_x);
               check_field("corner3_y", w.cy[3], rsp_corner3_y);
               check_field("degenerate", w.degenerate, rsp_degenerate);
               check_field("saturated", w.saturated, rsp_saturated);
            end
         end
      end
   end

endmodule

// ===== verif/testbench.sv =====
// stimulus and verdict for the quad expander
`timescale 1ns / 1ps

module testbench;
   import wsqe_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;
   localparam int ITEMS_PER_PHASE = 232;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_begin_x = '0, req_begin_y = '0, req_end_x = '0, req_end_y = '0;
   logic rsp_valid, rsp_degenerate, rsp_saturated;
   logic signed [15:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic signed [15:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HALF_WIDTH;
   logic [REG_BITS-1:0] csr_wdata = '0;
   int fail_count, words_pending;
   int stall_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   wide_segment_quad_expander_core uut (.*);
   quad_corner_checker checker_i (.*);

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_segment(int bx, int by, int ex, int ey, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_begin_x <= 16'(bx);
      req_begin_y <= 16'(by);
      req_end_x <= 16'(ex);
      req_end_y <= 16'(ey);
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [REG_BITS-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop sending, let the pipe empty, then wait out its latency
   task automatic drain_pipe();
      @(negedge clock);
      start <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_segment(int idle_pct);
      int bx, by, ex, ey, pick;
      pick = $urandom_range(9);
      bx = $signed(16'($urandom));
      by = $signed(16'($urandom));
      if (pick < 4) begin
         // short segments, realistic walls
         ex = bx + $signed(12'($urandom)) / (1 << $urandom_range(8));
         ey = by + $signed(12'($urandom)) / (1 << $urandom_range(8));
      end else if (pick == 4) begin
         ex = bx;
         ey = by;
      end else if (pick == 5) begin
         // begin x near the range edges
         bx = $urandom_range(1) ? 32767 - $urandom_range(200) : -32768 + $urandom_range(200);
         ex = bx + $signed(8'($urandom));
         ey = by + $signed(8'($urandom));
      end else if (pick == 6) begin
         // axis aligned
         ex = $urandom_range(1) ? bx : $signed(16'($urandom));
         ey = (ex == bx) ? $signed(16'($urandom)) : by;
      end else begin
         ex = $signed(16'($urandom));
         ey = $signed(16'($urandom));
      end
      send_segment(bx, by, ex, ey, idle_pct);
   endtask

   initial begin
      int idle_pct [5] = '{26, 45, 0, 26, 0};
      logic [REG_BITS-1:0] hw_set [5] = '{80, 0, 4095, 0, 4095};
      logic [REG_BITS-1:0] ext_set [5] = '{80, 4095, 0, 0, 4095};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 5; p++) begin
         if (p == 3) begin
            hw_set[p] = REG_BITS'($urandom);
            ext_set[p] = REG_BITS'($urandom);
         end
         write_csr(CSR_HALF_WIDTH, hw_set[p]);
         write_csr(CSR_END_EXTENSION, ext_set[p]);
         // index past the register list must be ignored
         write_csr(CSR_IDX_W'(CSR_END_EXTENSION + 1), REG_BITS'($urandom));
         write_csr(CSR_IDX_W'(CSR_END_EXTENSION + 2), REG_BITS'($urandom));

         // directed segments, among them the corners of the input space
         send_segment(0, 0, 0, 0, idle_pct[p]);
         send_segment(-32768, -32768, -32768, -32768, idle_pct[p]);
         send_segment(32767, 32767, 32767, 32767, idle_pct[p]);
         send_segment(-32768, -32768, 32767, 32767, idle_pct[p]);
         send_segment(32767, 32767, -32768, -32768, idle_pct[p]);
         send_segment(-32768, 32767, 32767, -32768, idle_pct[p]);
         send_segment(0, 0, 16, 0, idle_pct[p]);
         send_segment(0, 0, -16, 0, idle_pct[p]);
         send_segment(0, 0, 0, 16, idle_pct[p]);
         send_segment(0, 0, 0, -16, idle_pct[p]);
         send_segment(0, 0, 1, 1, idle_pct[p]);
         send_segment(0, 0, -1, -1, idle_pct[p]);
         send_segment(100, 200, 103, 204, idle_pct[p]);
         send_segment(32767, 0, 32700, 0, idle_pct[p]);
         send_segment(-32768, 0, -32700, 5, idle_pct[p]);
         send_segment(0, 32767, 0, 32000, idle_pct[p]);
         send_segment(0, -32768, 3, -32000, idle_pct[p]);
         send_segment(-21846, 21845, 21845, -21846, idle_pct[p]);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) random_segment(idle_pct[p]);
         drain_pipe();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wsqe_pkg.sv
rtl/wsqe_isqrt.sv
rtl/wsqe_div.sv
rtl/wide_segment_quad_expander_core.sv
verif/quad_corner_checker.sv
verif/testbench.sv
